>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds, consequent holds in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds, consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fprp_pkg.sv
// ----------------------------------------------------------------------------
// fprp_pkg
// Constants and register codes of the point rotate and project unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fprp_pkg;

  // fixed point unit, 1.0 = UNIT
  localparam int UNIT        = 10000;
  localparam int HALF_WIDTH  = 151;
  localparam int HALF_HEIGHT = 146;
  localparam int SX_MAX      = 2 * HALF_WIDTH + 1;
  localparam int SY_MAX      = 2 * HALF_HEIGHT + 1;

  // perspective factor magnitude beyond which every nonzero product saturates
  localparam int F_MAX       = 2 * UNIT * UNIT;
  // screen products beyond these bounds saturate the pixel
  localparam int P_HI        = UNIT * UNIT;
  localparam int P_LO        = -2 * UNIT * UNIT;

  // field widths
  localparam int COORD_W     = 15;
  localparam int TRIG_W      = 15;
  localparam int HZ_W        = 14;
  localparam int EYE_W       = 20;
  localparam int VS_W        = 14;
  localparam int PIX_W       = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;

  // stream packing
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_LAT   = 3'd0,
    CFG_SIN_LAT   = 3'd1,
    CFG_COS_LON   = 3'd2,
    CFG_SIN_LON   = 3'd3,
    CFG_HORIZON   = 3'd4,
    CFG_EYE_DIST  = 3'd5,
    CFG_VIEW_SCL  = 3'd6
  } cfg_idx_e;

endpackage

`default_nettype wire

>>> rtl/fixed_point_rotate_project_point_unit.sv
// ----------------------------------------------------------------------------
// Rotate and project unit: one shared multiplier and a radix-2 divider, 1 bit/cycle.
// A visible point runs the rotate, perspective and screen steps to a result beat; a hidden
// one ends after the depth divide, with no result. One point is in work at a time; the
// 36-step perspective divide takes most of the time, each divide by 10000 uses the multiplier.
// Reset: async, active low; configuration registers to defaults, pen history clear, stream idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fixed_point_rotate_project_point_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [fprp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [fprp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input stream
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // point_x [14:0], point_y [29:15], point_z [44:30], zero pad [47:45]
  input  wire logic [fprp_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // pen_down [0]
  input  wire logic                                s_axis_tuser,
  // result stream
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // screen_x [8:0], screen_y [17:9], zero pad [23:18]
  output      logic [fprp_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // line_flag [0]
  output      logic                                m_axis_tuser
);
  import fprp_pkg::*;

  localparam int A_W   = 28;   // multiplier operand a
  localparam int B_W   = 29;   // multiplier operand b
  localparam int P_W   = 57;   // product and accumulator
  localparam int DVD_W = 36;   // dividend / quotient magnitude
  localparam int DVS_W = 21;   // divisor magnitude
  localparam int CNT_W = 6;
  localparam int Q_W   = DVD_W + 1;
  localparam int T_W   = 17;
  localparam int D_W   = 18;
  localparam int DEN_W = 22;
  localparam int F_W   = 29;
  localparam int W_W   = 16;
  // 10000 = 16 * 625; n/625 = (n * RCP_625) >> RCP_SH, exact for n below 2^27
  localparam int UNIT_SH = 4;
  localparam int RCP_625 = 219902326;
  localparam int RCP_SH  = 37;
  localparam int RQ_W    = 18;

  typedef enum logic [23:0] {
    ST_IDLE = 24'h000001,
    ST_MT0  = 24'h000002,
    ST_MT1  = 24'h000004,
    ST_DT   = 24'h000008,
    ST_MD0  = 24'h000010,
    ST_MD1  = 24'h000020,
    ST_DD   = 24'h000040,
    ST_MU0  = 24'h000080,
    ST_MU1  = 24'h000100,
    ST_DU   = 24'h000200,
    ST_MV0  = 24'h000400,
    ST_MV1  = 24'h000800,
    ST_DV   = 24'h001000,
    ST_MF   = 24'h002000,
    ST_DF   = 24'h004000,
    ST_MPX  = 24'h008000,
    ST_DPX  = 24'h010000,
    ST_MSX  = 24'h020000,
    ST_DSX  = 24'h040000,
    ST_MPY  = 24'h080000,
    ST_DPY  = 24'h100000,
    ST_MSY  = 24'h200000,
    ST_DSY  = 24'h400000,
    ST_OUT  = 24'h800000
  } state_e;

  // control
  state_e                   state_q, state_d;
  logic                     div_busy_q, div_busy_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     prev_hidden_q, prev_hidden_d;
  logic                     out_valid_q, out_valid_d;

  // configuration
  logic signed [TRIG_W-1:0] cos_lat_q, sin_lat_q, cos_lon_q, sin_lon_q;
  logic [HZ_W-1:0]          horizon_q;
  logic [EYE_W-1:0]         eye_q;
  logic [VS_W-1:0]          vscale_q;

  // point and intermediates
  logic signed [COORD_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic                      line_q, line_d;
  logic signed [P_W-1:0]     acc_q, acc_d;
  logic signed [T_W-1:0]     t_q, t_d, u_q, u_d;
  logic signed [D_W-1:0]     d_q, d_d, v_q, v_d;
  logic signed [F_W-1:0]     f_q, f_d;
  logic signed [W_W-1:0]     w_q, w_d;
  logic [PIX_W-1:0]          sx_q, sx_d, sy_q, sy_d;

  // divider
  logic [DVD_W-1:0]          dvd_q, dvd_d;
  logic [DVS_W-1:0]          rem_q, rem_d;
  logic [DVS_W-1:0]          dvs_q, dvs_d;
  logic                      qneg_q, qneg_d;

  // result register
  logic [PIX_W-1:0]          mx_q, mx_d, my_q, my_d;
  logic                      mline_q, mline_d;

  // shared multiplier
  logic signed [A_W-1:0]     mul_a;
  logic signed [B_W-1:0]     mul_b;
  logic signed [P_W-1:0]     prod;
  logic                      acc_en, acc_clr, acc_neg;

  logic                      is_div, is_pdiv, is_udiv, rcp_step;
  logic signed [P_W-1:0]     acc_c;
  logic [P_W-1:0]            acc_mag;
  logic signed [DEN_W-1:0]   den;
  logic [DEN_W-1:0]          den_mag;
  logic [DVS_W:0]            shifted, trial;
  logic [DVD_W-1:0]          quo;
  logic signed [Q_W-1:0]     q_s, sraw, hz_ext;
  logic [F_W-2:0]            f_mag;

  assign is_pdiv = (state_q == ST_DPX) || (state_q == ST_DPY);

  always_comb begin
    is_div = state_q inside {ST_DT, ST_DD, ST_DU, ST_DV, ST_DF, ST_DPX, ST_DSX,
                             ST_DPY, ST_DSY};
  end

  // every divide but the perspective one is by UNIT
  assign is_udiv  = is_div && (state_q != ST_DF);
  assign rcp_step = is_udiv && div_busy_q && (cnt_q != '0);

  // operand select for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    acc_en  = 1'b1;
    acc_clr = 1'b1;
    acc_neg = 1'b0;
    case (state_q)
      ST_MT0: begin mul_a = A_W'(x_q); mul_b = B_W'(cos_lon_q); end
      ST_MT1: begin mul_a = A_W'(y_q); mul_b = B_W'(sin_lon_q); acc_clr = 1'b0; end
      ST_MD0: begin mul_a = A_W'(t_q); mul_b = B_W'(cos_lat_q); end
      ST_MD1: begin mul_a = A_W'(z_q); mul_b = B_W'(sin_lat_q); acc_clr = 1'b0; end
      ST_MU0: begin mul_a = A_W'(y_q); mul_b = B_W'(cos_lon_q); end
      ST_MU1: begin
        mul_a = A_W'(x_q); mul_b = B_W'(sin_lon_q); acc_clr = 1'b0; acc_neg = 1'b1;
      end
      ST_MV0: begin mul_a = A_W'(z_q); mul_b = B_W'(cos_lat_q); end
      ST_MV1: begin
        mul_a = A_W'(t_q); mul_b = B_W'(sin_lat_q); acc_clr = 1'b0; acc_neg = 1'b1;
      end
      ST_MF:  begin mul_a = A_W'(eye_q); mul_b = B_W'(vscale_q); end
      ST_MPX: begin mul_a = A_W'(u_q); mul_b = B_W'(f_q); end
      ST_MSX: begin mul_a = A_W'(w_q); mul_b = B_W'(HALF_WIDTH); end
      ST_MPY: begin mul_a = A_W'(v_q); mul_b = B_W'(f_q); acc_neg = 1'b1; end
      ST_MSY: begin mul_a = A_W'(w_q); mul_b = B_W'(HALF_HEIGHT); end
      default: acc_en = 1'b0;
    endcase
    // divide by UNIT: shifted magnitude times the reciprocal of 625
    if (rcp_step) begin
      mul_a  = A_W'(dvd_q);
      mul_b  = B_W'(RCP_625);
      acc_en = 1'b1;
    end
  end

  assign prod = mul_a * mul_b;

  // dividend: accumulator, clamped on the screen products
  always_comb begin
    acc_c = acc_q;
    if (is_pdiv) begin
      if (acc_q > P_W'(P_HI)) begin
        acc_c = P_W'(P_HI);
      end else if (acc_q < P_W'(P_LO)) begin
        acc_c = P_W'(P_LO);
      end
    end
    acc_mag = acc_c[P_W-1] ? P_W'(-acc_c) : P_W'(acc_c);
  end

  // perspective divisor, a zero divisor counts as one
  always_comb begin
    den     = $signed({2'b00, eye_q}) - DEN_W'(d_q);
    den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    if (den == '0) begin
      den_mag = DEN_W'(1);
    end
  end

  assign shifted = {rem_q, dvd_q[DVD_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign quo     = is_udiv ? DVD_W'(acc_q[RCP_SH +: RQ_W]) : dvd_q;
  assign q_s     = qneg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign sraw    = q_s + Q_W'(1);
  assign hz_ext  = Q_W'($signed({1'b0, horizon_q}));
  assign f_mag   = (dvd_q > DVD_W'(F_MAX)) ? (F_W-1)'(F_MAX) : dvd_q[F_W-2:0];

  always_comb begin
    state_d       = state_q;
    div_busy_d    = div_busy_q;
    cnt_d         = cnt_q;
    prev_hidden_d = prev_hidden_q;
    out_valid_d   = out_valid_q & ~m_axis_tready;
    x_d = x_q; y_d = y_q; z_d = z_q; line_d = line_q;
    acc_d = acc_q;
    t_d = t_q; u_d = u_q; d_d = d_q; v_d = v_q; f_d = f_q; w_d = w_q;
    sx_d = sx_q; sy_d = sy_q;
    dvd_d = dvd_q; rem_d = rem_q; dvs_d = dvs_q; qneg_d = qneg_q;
    mx_d = mx_q; my_d = my_q; mline_d = mline_q;

    if (acc_en) begin
      acc_d = (acc_clr ? P_W'(0) : acc_q) + (acc_neg ? -prod : prod);
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          x_d     = s_axis_tdata[COORD_W-1:0];
          y_d     = s_axis_tdata[2*COORD_W-1:COORD_W];
          z_d     = s_axis_tdata[3*COORD_W-1:2*COORD_W];
          line_d  = s_axis_tuser & ~prev_hidden_q;
          state_d = ST_MT0;
        end
      end
      ST_MT0: state_d = ST_MT1;
      ST_MT1: state_d = ST_DT;
      ST_MD0: state_d = ST_MD1;
      ST_MD1: state_d = ST_DD;
      ST_MU0: state_d = ST_MU1;
      ST_MU1: state_d = ST_DU;
      ST_MV0: state_d = ST_MV1;
      ST_MV1: state_d = ST_DV;
      ST_MF:  state_d = ST_DF;
      ST_MPX: state_d = ST_DPX;
      ST_MSX: state_d = ST_DSX;
      ST_MPY: state_d = ST_DPY;
      ST_MSY: state_d = ST_DSY;
      ST_OUT: begin
        // hold until the result register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          mx_d        = sx_q;
          my_d        = sy_q;
          mline_d     = line_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = state_q;
    endcase

    if (is_div) begin
      if (!div_busy_q) begin
        // load magnitudes, quotient sign kept aside
        dvd_d      = is_udiv ? DVD_W'(acc_mag >> UNIT_SH) : acc_mag[DVD_W-1:0];
        rem_d      = '0;
        dvs_d      = (state_q == ST_DF) ? den_mag[DVS_W-1:0] : DVS_W'(UNIT);
        qneg_d     = acc_c[P_W-1] ^ ((state_q == ST_DF) && den[DEN_W-1]);
        cnt_d      = is_udiv ? CNT_W'(1) : CNT_W'(DVD_W);
        div_busy_d = 1'b1;
      end else if (cnt_q != '0) begin
        if (!is_udiv) begin
          if (!trial[DVS_W]) begin
            rem_d = trial[DVS_W-1:0];
          end else begin
            rem_d = shifted[DVS_W-1:0];
          end
          dvd_d = {dvd_q[DVD_W-2:0], ~trial[DVS_W]};
        end
        cnt_d = cnt_q - CNT_W'(1);
      end else begin
        div_busy_d = 1'b0;
        case (state_q)
          ST_DT: begin
            t_d     = q_s[T_W-1:0];
            state_d = ST_MD0;
          end
          ST_DD: begin
            d_d           = q_s[D_W-1:0];
            prev_hidden_d = (q_s < hz_ext);
            // drop a hidden point without a result
            state_d       = (q_s < hz_ext) ? ST_IDLE : ST_MU0;
          end
          ST_DU: begin
            u_d     = q_s[T_W-1:0];
            state_d = ST_MV0;
          end
          ST_DV: begin
            v_d     = q_s[D_W-1:0];
            state_d = ST_MF;
          end
          ST_DF: begin
            f_d     = qneg_q ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});
            state_d = ST_MPX;
          end
          ST_DPX, ST_DPY: begin
            w_d     = q_s[W_W-1:0] + W_W'(UNIT);
            state_d = (state_q == ST_DPX) ? ST_MSX : ST_MSY;
          end
          ST_DSX: begin
            if (sraw[Q_W-1]) begin
              sx_d = '0;
            end else if (sraw > Q_W'(SX_MAX)) begin
              sx_d = PIX_W'(SX_MAX);
            end else begin
              sx_d = sraw[PIX_W-1:0];
            end
            state_d = ST_MPY;
          end
          ST_DSY: begin
            if (sraw[Q_W-1]) begin
              sy_d = '0;
            end else if (sraw > Q_W'(SY_MAX)) begin
              sy_d = PIX_W'(SY_MAX);
            end else begin
              sy_d = sraw[PIX_W-1:0];
            end
            state_d = ST_OUT;
          end
          default: state_d = state_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      div_busy_q    <= 1'b0;
      cnt_q         <= '0;
      prev_hidden_q <= 1'b0;
      out_valid_q   <= 1'b0;
      cos_lat_q     <= TRIG_W'(UNIT);
      sin_lat_q     <= '0;
      cos_lon_q     <= TRIG_W'(UNIT);
      sin_lon_q     <= '0;
      horizon_q     <= HZ_W'(5000);
      eye_q         <= EYE_W'(20000);
      vscale_q      <= VS_W'(8660);
    end else begin
      state_q       <= state_d;
      div_busy_q    <= div_busy_d;
      cnt_q         <= cnt_d;
      prev_hidden_q <= prev_hidden_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_COS_LAT:  cos_lat_q <= cfg_data_i[TRIG_W-1:0];
          CFG_SIN_LAT:  sin_lat_q <= cfg_data_i[TRIG_W-1:0];
          CFG_COS_LON:  cos_lon_q <= cfg_data_i[TRIG_W-1:0];
          CFG_SIN_LON:  sin_lon_q <= cfg_data_i[TRIG_W-1:0];
          CFG_HORIZON:  horizon_q <= cfg_data_i[HZ_W-1:0];
          CFG_EYE_DIST: eye_q     <= cfg_data_i[EYE_W-1:0];
          CFG_VIEW_SCL: vscale_q  <= cfg_data_i[VS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    line_q  <= line_d;
    acc_q   <= acc_d;
    t_q     <= t_d;
    u_q     <= u_d;
    d_q     <= d_d;
    v_q     <= v_d;
    f_q     <= f_d;
    w_q     <= w_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    qneg_q  <= qneg_d;
    mx_q    <= mx_d;
    my_q    <= my_d;
    mline_q <= mline_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - 2*PIX_W)'(0), my_q, mx_q};
  assign m_axis_tuser  = mline_q;

  `ASSERT_IMPL(a_result_from_out_state, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_OUT), "result loaded outside the output step")
  `ASSERT_IMPL(a_divider_in_div_step, clk_i, rst_ni, div_busy_q, is_div, "divider running outside a divide step")
  `ASSERT_NEXT(a_no_accept_while_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a point is in work")
  `ASSERT_IMPL(a_pixel_in_window, clk_i, rst_ni, out_valid_q, (mx_q <= PIX_W'(SX_MAX)) && (my_q <= PIX_W'(SY_MAX)), "pixel outside the window")

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotate and project unit testbench
// Streams points into the unit and checks each screen pixel beat against a
// fixed point predictor. Two directed passes cover the corners and the special
// cases. Random phases under many views then follow, with random gaps on
// both streams.
// ----------------------------------------------------------------------------

import fprp_pkg::*;

typedef struct {
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic signed [COORD_W-1:0] z;
  logic                      pen;
} sphere_point_t;

typedef struct {
  logic [PIX_W-1:0] screen_x;
  logic [PIX_W-1:0] screen_y;
  logic             line_flag;
} screen_pixel_t;

class pixel_predictor;
  longint cos_lat, sin_lat, cos_lon, sin_lon;
  longint horizon, eye_dist, view_scl;
  bit prev_hidden;
  screen_pixel_t expected_pixels[$];
  int failures;

  function new();
    cos_lat     = UNIT;
    sin_lat     = 0;
    cos_lon     = UNIT;
    sin_lon     = 0;
    horizon     = 5000;
    eye_dist    = 20000;
    view_scl    = 8660;
    prev_hidden = 1'b0;
    failures    = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_COS_LAT:  cos_lat  = longint'(signed'(data[TRIG_W-1:0]));
      CFG_SIN_LAT:  sin_lat  = longint'(signed'(data[TRIG_W-1:0]));
      CFG_COS_LON:  cos_lon  = longint'(signed'(data[TRIG_W-1:0]));
      CFG_SIN_LON:  sin_lon  = longint'(signed'(data[TRIG_W-1:0]));
      CFG_HORIZON:  horizon  = longint'(data[HZ_W-1:0]);
      CFG_EYE_DIST: eye_dist = longint'(data[EYE_W-1:0]);
      CFG_VIEW_SCL: view_scl = longint'(data[VS_W-1:0]);
      default: ;
    endcase
  endfunction

  static function longint clamp_pix(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Rotate by longitude, then latitude; project when above the horizon.
  function void note_point(sphere_point_t p);
    longint px, py, pz, t, d, u, v, den, f, sx, sy;
    bit line;
    screen_pixel_t pix;
    px = p.x;
    py = p.y;
    pz = p.z;
    line = p.pen && !prev_hidden;
    t = (px * cos_lon + py * sin_lon) / UNIT;
    d = (t * cos_lat + pz * sin_lat) / UNIT;
    prev_hidden = (d < horizon);
    if (prev_hidden) return;
    u = (py * cos_lon - px * sin_lon) / UNIT;
    v = (pz * cos_lat - t * sin_lat) / UNIT;
    den = eye_dist - d;
    if (den == 0) den = 1;
    f = (eye_dist * view_scl) / den;
    sx = (((u * f) / UNIT + UNIT) * HALF_WIDTH) / UNIT + 1;
    sy = (((-v * f) / UNIT + UNIT) * HALF_HEIGHT) / UNIT + 1;
    pix.screen_x  = PIX_W'(clamp_pix(sx, SX_MAX));
    pix.screen_y  = PIX_W'(clamp_pix(sy, SY_MAX));
    pix.line_flag = line;
    expected_pixels.push_back(pix);
  endfunction

  function void check_pixel(screen_pixel_t got);
    screen_pixel_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel beat: screen_x %0d screen_y %0d line_flag %0d",
             got.screen_x, got.screen_y, got.line_flag);
      failures++;
      return;
    end
    want = expected_pixels.pop_front();
    if (got.screen_x !== want.screen_x) begin
      $error("screen_x mismatch: expected %0d, actual %0d", want.screen_x, got.screen_x);
      failures++;
    end
    if (got.screen_y !== want.screen_y) begin
      $error("screen_y mismatch: expected %0d, actual %0d", want.screen_y, got.screen_y);
      failures++;
    end
    if (got.line_flag !== want.line_flag) begin
      $error("line_flag mismatch: expected %0d, actual %0d", want.line_flag, got.line_flag);
      failures++;
    end
  endfunction
endclass

module testbench;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
  localparam int IDLE_CYCLES = 100;   // covers a hidden point still in flight
  localparam int TAIL_CYCLES = 400;   // longer than a visible point's latency
  localparam int QUIET_LIMIT = 4000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;   // point_x, point_y, point_z, zero pad
  logic                  s_axis_tuser;   // pen_down
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;   // screen_x, screen_y, zero pad
  logic                  m_axis_tuser;   // line_flag

  pixel_predictor tracker;
  bit             in_calm;
  bit             out_calm;
  longint         view_regs[7];
  bit             view_raw;
  int             quiet_cycles;

  fixed_point_rotate_project_point_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic int reg_width(cfg_idx_e r);
    case (r)
      CFG_HORIZON:  return HZ_W;
      CFG_EYE_DIST: return EYE_W;
      CFG_VIEW_SCL: return VS_W;
      default:      return TRIG_W;
    endcase
  endfunction

  function automatic sphere_point_t point_at(int x, int y, int z, bit pen);
    sphere_point_t p;
    p.x   = COORD_W'(x);
    p.y   = COORD_W'(y);
    p.z   = COORD_W'(z);
    p.pen = pen;
    return p;
  endfunction

  // Mostly points on the sphere; some raw codes and some in-range noise.
  function automatic sphere_point_t make_point();
    sphere_point_t p;
    real lat, lon;
    int kind;
    kind = $urandom_range(0, 19);
    if (kind < 15) begin
      lat = ($urandom_range(0, 31415) - 15707) / 10000.0;
      lon = $urandom_range(0, 62831) / 10000.0;
      p.x = COORD_W'($rtoi(UNIT * $cos(lat) * $cos(lon)));
      p.y = COORD_W'($rtoi(UNIT * $cos(lat) * $sin(lon)));
      p.z = COORD_W'($rtoi(UNIT * $sin(lat)));
    end else if (kind < 18) begin
      p.x = COORD_W'($urandom);
      p.y = COORD_W'($urandom);
      p.z = COORD_W'($urandom);
    end else begin
      p.x = COORD_W'($urandom_range(0, 2 * UNIT) - UNIT);
      p.y = COORD_W'($urandom_range(0, 2 * UNIT) - UNIT);
      p.z = COORD_W'($urandom_range(0, 2 * UNIT) - UNIT);
    end
    p.pen = $urandom_range(0, 1);
    return p;
  endfunction

  task automatic set_view(longint cl, longint sl, longint co, longint so,
                          longint hz, longint eye, longint vs);
    view_regs[CFG_COS_LAT]  = cl;
    view_regs[CFG_SIN_LAT]  = sl;
    view_regs[CFG_COS_LON]  = co;
    view_regs[CFG_SIN_LON]  = so;
    view_regs[CFG_HORIZON]  = hz;
    view_regs[CFG_EYE_DIST] = eye;
    view_regs[CFG_VIEW_SCL] = vs;
    view_raw = 1'b0;
  endtask

  // Real viewing angles; the remaining registers come from the caller.
  task automatic aim_view(longint hz, longint eye, longint vs);
    real lat, lon;
    lat = ($urandom_range(0, 31415) - 15707) / 10000.0;
    lon = $urandom_range(0, 62831) / 10000.0;
    set_view($rtoi(UNIT * $cos(lat)), $rtoi(UNIT * $sin(lat)),
             $rtoi(UNIT * $cos(lon)), $rtoi(UNIT * $sin(lon)), hz, eye, vs);
  endtask

  task automatic choose_view(int phase);
    case (phase)
      0: aim_view(0, 10001, 10000);
      1: set_view(UNIT, 0, UNIT, 0, 10000, 1000000, 0);
      2: set_view(-UNIT, UNIT, -UNIT, UNIT, 0, 1000000, 10000);
      3: set_view(0, -UNIT, 0, -UNIT, 2000, 12000, 5000);
      7: view_raw = 1'b1;
      default: aim_view($urandom_range(0, 4000), $urandom_range(10001, 60000),
                        $urandom_range(0, 10000));
    endcase
  endtask

  // Write every register, unused bits random (all bits in raw mode), then the unused index.
  task automatic program_view();
    cfg_idx_e r;
    logic [CFG_DATA_W-1:0] data, keep;
    r = r.first();
    repeat (r.num()) begin
      keep = CFG_DATA_W'((longint'(1) << reg_width(r)) - 1);
      data = CFG_DATA_W'($urandom);
      if (!view_raw) data = (data & ~keep) | (CFG_DATA_W'(view_regs[r]) & keep);
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= r;
      cfg_data_i <= data;
      @(posedge clk_i);
      tracker.set_reg(r, data);
      r = r.next();
    end
    data = CFG_DATA_W'($urandom);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_NO_REG;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.set_reg(CFG_NO_REG, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold tvalid high from one beat to the next unless a gap is drawn.
  task automatic send_point(sphere_point_t p);
    int gap;
    gap = draw_gap(in_calm);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - 3 * COORD_W){1'b0}}, p.z, p.y, p.x};
    s_axis_tuser  <= p.pen;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_point(p);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic settle(int cycles);
    while (tracker.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  // Either raise tready ahead of the result or hold it off until tvalid shows.
  task automatic collect_pixels();
    int stall;
    bit wait_valid;
    screen_pixel_t got;
    forever begin
      stall = draw_gap(out_calm);
      wait_valid = !out_calm && ($urandom_range(0, 1) == 1);
      @(negedge clk_i);
      if (wait_valid || stall != 0) begin
        m_axis_tready <= 1'b0;
        if (wait_valid) begin
          do @(posedge clk_i); while (!m_axis_tvalid);
          @(negedge clk_i);
        end
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.screen_x  = m_axis_tdata[PIX_W-1:0];
      got.screen_y  = m_axis_tdata[2*PIX_W-1:PIX_W];
      got.line_flag = m_axis_tuser;
      tracker.check_pixel(got);
    end
  endtask

  initial begin : main
    int phase;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    quiet_cycles  = 0;
    in_calm       = 1'b0;
    out_calm      = 1'b0;
    tracker       = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    fork
      collect_pixels();
    join_none

    // Default view: identity rotation, so depth is point_x.
    send_point(point_at(10000, 0, 0, 1));
    send_point(point_at(10000, 10000, 10000, 1));
    send_point(point_at(10000, -10000, -10000, 0));
    send_point(point_at(-10000, 0, 0, 1));
    send_point(point_at(10000, 0, 0, 1));
    send_point(point_at(5000, 0, 0, 1));
    send_point(point_at(4999, 0, 0, 0));
    send_point(point_at(16383, 16383, 16383, 1));
    send_point(point_at(-16384, -16384, -16384, 1));
    send_point(point_at(16383, -16384, 0, 1));
    send_point(point_at(7071, -7071, 7071, 1));
    send_point(point_at(10000, -1, 1, 1));
    send_point(point_at(9999, 1, -1, 0));
    send_point(point_at(8000, 6000, 0, 1));
    end_burst();
    settle(IDLE_CYCLES);

    // Eye on the sphere: zero and negative perspective denominators.
    set_view(UNIT, 0, UNIT, 0, 0, 10000, 10000);
    program_view();
    send_point(point_at(10000, 0, 0, 1));
    send_point(point_at(16383, 5000, -5000, 1));
    send_point(point_at(0, 100, -100, 1));
    send_point(point_at(-1, 0, 0, 1));
    send_point(point_at(0, 0, 0, 1));
    send_point(point_at(10000, 1, -1, 1));
    end_burst();
    settle(IDLE_CYCLES);

    for (phase = 0; phase < 8; phase++) begin
      choose_view(phase);
      program_view();
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      repeat ((phase == 1) ? 40 : 85) send_point(make_point());
      end_burst();
      settle((phase == 7) ? TAIL_CYCLES : IDLE_CYCLES);
    end

    if (tracker.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> fixed_point_rotate_project_point_unit.f
+incdir+rtl
rtl/fprp_pkg.sv
rtl/fixed_point_rotate_project_point_unit.sv
test/testbench.sv
